[src/led_matrix_column_scanner_assert.svh]
// Assertion macros for the LED matrix column scanner.
`ifndef LED_MATRIX_COLUMN_SCANNER_ASSERT_SVH
`define LED_MATRIX_COLUMN_SCANNER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LMCS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define LMCS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/lmcs_pkg.sv]
// Package: shared types and constants of the LED matrix column scanner.
`timescale 1ns / 1ps
package lmcs_pkg;

   localparam int COLUMNS         = 8;
   localparam int COL_W           = 3;
   localparam int BYTE_W          = 8;
   localparam int POS_W           = BYTE_W + 1;
   localparam int DWELL_W         = 24;
   localparam int FRAME_W         = 14;
   localparam int STATIC_FRAMES   = 50;
   localparam int SCROLL_FRAMES   = 10;
   localparam int DWELL_RESET     = 7812;
   localparam int SECONDS_RESET   = 1;
   localparam int LENGTH_RESET    = 8;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_START = 2'd2
   } lmcs_op_type;

   typedef enum logic [1:0] {
      CSR_SCROLL_MODE     = 2'd0,
      CSR_DISPLAY_SECONDS = 2'd1,
      CSR_MESSAGE_LENGTH  = 2'd2,
      CSR_DWELL_TICKS     = 2'd3
   } lmcs_csr_type;

   typedef struct packed {
      logic             show;
      logic             running;
      logic             done;
      logic [COL_W-1:0] column;
   } lmcs_meta_type;

endpackage

[src/lmcs_store.sv]
// Message store: single-port write, registered read.
`timescale 1ns / 1ps
module lmcs_store import lmcs_pkg::*; #(
   parameter int MSG_DEPTH = 256
) (
   input  logic                         clock,
   input  logic                         we,
   input  logic [$clog2(MSG_DEPTH)-1:0] waddr,
   input  logic [BYTE_W-1:0]            wdata,
   input  logic                         re,
   input  logic [$clog2(MSG_DEPTH)-1:0] raddr,
   output logic [BYTE_W-1:0]            rdata
);

   logic [BYTE_W-1:0] store_ff [MSG_DEPTH];
   logic [BYTE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= store_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[src/lmcs_ctrl.sv]
// Scan control: config registers, dwell/column/frame/window counters, store access.
`timescale 1ns / 1ps
module lmcs_ctrl import lmcs_pkg::*; #(
   parameter int MSG_DEPTH = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [1:0]                   opcode,
   input  logic [BYTE_W-1:0]            byte_index,
   input  logic [BYTE_W-1:0]            byte_value,
   input  logic                         csr_write,
   input  logic [1:0]                   csr_index,
   input  logic [DWELL_W-1:0]           csr_wdata,
   output logic                         mem_we,
   output logic [$clog2(MSG_DEPTH)-1:0] mem_waddr,
   output logic [BYTE_W-1:0]            mem_wdata,
   output logic                         mem_re,
   output logic [$clog2(MSG_DEPTH)-1:0] mem_raddr,
   output lmcs_meta_type                meta
);

   localparam int AW = $clog2(MSG_DEPTH);

   logic               scroll_ff;
   logic [BYTE_W-1:0]  seconds_ff;
   logic [BYTE_W-1:0]  length_ff;
   logic [DWELL_W-1:0] dwell_ticks_ff;

   logic               busy_ff, busy_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [DWELL_W-1:0] dwell_ff, dwell_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [BYTE_W-1:0]  window_ff, window_in;

   logic [DWELL_W-1:0] dwell_inc;
   logic [COL_W-1:0]   col_inc;
   logic [FRAME_W-1:0] frame_inc;
   logic [FRAME_W-1:0] frame_target;
   logic [BYTE_W-1:0]  window_inc;
   logic [BYTE_W-1:0]  base;
   logic [POS_W-1:0]   rd_pos;
   logic               rd_hit;
   logic               done;
   logic               empty_seq;
   logic               write_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         scroll_ff      <= 1'b0;
         seconds_ff     <= BYTE_W'(SECONDS_RESET);
         length_ff      <= BYTE_W'(LENGTH_RESET);
         dwell_ticks_ff <= DWELL_W'(DWELL_RESET);
      end else if (csr_write) begin
         case (csr_index)
            CSR_SCROLL_MODE:     scroll_ff      <= csr_wdata[0];
            CSR_DISPLAY_SECONDS: seconds_ff     <= csr_wdata[BYTE_W-1:0];
            CSR_MESSAGE_LENGTH:  length_ff      <= csr_wdata[BYTE_W-1:0];
            CSR_DWELL_TICKS:     dwell_ticks_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      dwell_inc    = dwell_ff + DWELL_W'(1);
      col_inc      = col_ff + COL_W'(1);
      frame_inc    = frame_ff + FRAME_W'(1);
      window_inc   = window_ff + BYTE_W'(1);
      frame_target = scroll_ff ? FRAME_W'(SCROLL_FRAMES)
                               : FRAME_W'(seconds_ff) * FRAME_W'(STATIC_FRAMES);
      empty_seq    = scroll_ff ? (length_ff <= BYTE_W'(COLUMNS))
                               : (seconds_ff == '0);
      write_ok     = {1'b0, byte_index} < POS_W'(MSG_DEPTH);

      busy_in   = busy_ff;
      col_in    = col_ff;
      dwell_in  = dwell_ff;
      frame_in  = frame_ff;
      window_in = window_ff;
      done      = 1'b0;
      mem_we    = 1'b0;

      if (accept) begin
         case (opcode)
            OP_TICK: begin
               if (busy_ff) begin
                  if (dwell_inc < dwell_ticks_ff) begin
                     dwell_in = dwell_inc;
                  end else begin
                     dwell_in = '0;
                     col_in   = col_inc;
                     if (col_inc == '0) begin
                        if (frame_inc < frame_target) begin
                           frame_in = frame_inc;
                        end else begin
                           frame_in = '0;
                           if (!scroll_ff) begin
                              busy_in = 1'b0;
                              done    = 1'b1;
                           end else begin
                              window_in = window_inc;
                              if ({1'b0, window_inc} + POS_W'(COLUMNS) >= {1'b0, length_ff})
                              begin
                                 busy_in = 1'b0;
                                 done    = 1'b1;
                              end
                           end
                        end
                     end
                  end
               end
            end
            OP_WRITE: begin
               mem_we = !busy_ff && write_ok;
            end
            OP_START: begin
               if (!busy_ff) begin
                  col_in    = '0;
                  dwell_in  = '0;
                  frame_in  = '0;
                  window_in = '0;
                  if (empty_seq) begin
                     done = 1'b1;
                  end else begin
                     busy_in = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end

      base   = scroll_ff ? window_in : '0;
      rd_pos = {1'b0, base} + POS_W'(col_in);
      rd_hit = busy_in && (rd_pos < POS_W'(MSG_DEPTH));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         col_ff    <= '0;
         dwell_ff  <= '0;
         frame_ff  <= '0;
         window_ff <= '0;
      end else if (accept) begin
         busy_ff   <= busy_in;
         col_ff    <= col_in;
         dwell_ff  <= dwell_in;
         frame_ff  <= frame_in;
         window_ff <= window_in;
      end
   end

   assign mem_waddr    = byte_index[AW-1:0];
   assign mem_wdata    = byte_value;
   assign mem_re       = accept && rd_hit;
   assign mem_raddr    = rd_pos[AW-1:0];
   assign meta.show    = rd_hit;
   assign meta.running = busy_in;
   assign meta.done    = done;
   assign meta.column  = col_in;

endmodule

[src/lmcs_out.sv]
// Response path: read-data stage plus output register, two requests of buffering.
`timescale 1ns / 1ps
module lmcs_out import lmcs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  lmcs_meta_type       meta,
   input  logic [BYTE_W-1:0]   rdata,
   input  logic                rsp_stall,
   output logic                s1_free,
   output logic                s1_valid,
   output logic                rsp_valid,
   output logic [BYTE_W-1:0]   rsp_row_lines,
   output logic [COLUMNS-1:0]  rsp_column_lines,
   output logic                rsp_running,
   output logic                rsp_done_res
);

   logic                s1_valid_ff;
   lmcs_meta_type       s1_meta_ff;
   logic                out_valid_ff;
   logic [BYTE_W-1:0]   row_ff;
   logic [COLUMNS-1:0]  column_ff;
   logic                running_ff;
   logic                done_ff;

   logic                out_free;
   logic                s1_move;
   logic [COLUMNS-1:0]  column_in;
   logic [BYTE_W-1:0]   row_in;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign s1_move  = s1_valid_ff && out_free;
   assign s1_free  = !s1_valid_ff || s1_move;

   always_comb begin
      row_in    = s1_meta_ff.show ? rdata : '0;
      column_in = s1_meta_ff.running ? ~(COLUMNS'(1) << s1_meta_ff.column) : '1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_meta_ff <= meta;
      end
      if (s1_move) begin
         row_ff     <= row_in;
         column_ff  <= column_in;
         running_ff <= s1_meta_ff.running;
         done_ff    <= s1_meta_ff.done;
      end
   end

   assign s1_valid         = s1_valid_ff;
   assign rsp_valid        = out_valid_ff;
   assign rsp_row_lines    = row_ff;
   assign rsp_column_lines = column_ff;
   assign rsp_running      = running_ff;
   assign rsp_done_res     = done_ff;

endmodule

[src/led_matrix_column_scanner.sv]
// Top level: 8x8 LED matrix column scanner with static and scrolling display.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | opcode, byte_index, byte_value
//   rsp     | out       | rsp_valid / rsp_stall | row_lines, column_lines, running, done_res
//   csr     | in        | csr_valid / csr_ready | csr_index, csr_wdata
//
// One request per clock while req_stall is low; each response passes the read-data stage, then the output register.
// Latency is set by the synchronous message store read plus the output register.
// Up to two responses are buffered; req_stall rises only when both slots are full.
// Synchronous reset clears control state and loads register defaults; the store is not cleared.
// csr_ready is always high; register writes take effect on the next request.
`timescale 1ns / 1ps
module led_matrix_column_scanner import lmcs_pkg::*; #(
   parameter int MSG_DEPTH = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_opcode,
   input  logic [BYTE_W-1:0]   req_byte_index,
   input  logic [BYTE_W-1:0]   req_byte_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [BYTE_W-1:0]   rsp_row_lines,
   output logic [COLUMNS-1:0]  rsp_column_lines,
   output logic                rsp_running,
   output logic                rsp_done_res,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [DWELL_W-1:0]  csr_wdata
);

`include "led_matrix_column_scanner_assert.svh"

   localparam int AW = $clog2(MSG_DEPTH);

   logic              accept;
   logic              s1_free;
   logic              s1_valid;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [BYTE_W-1:0] mem_wdata;
   logic              mem_re;
   logic [AW-1:0]     mem_raddr;
   logic [BYTE_W-1:0] mem_rdata;
   lmcs_meta_type     meta;
   logic              rsp_active;

   assign req_stall  = !s1_free;
   assign accept     = req_valid && s1_free;
   assign csr_ready  = 1'b1;
   assign rsp_active = rsp_valid && rsp_running;

   lmcs_ctrl #(.MSG_DEPTH(MSG_DEPTH)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .opcode     (req_opcode),
      .byte_index (req_byte_index),
      .byte_value (req_byte_value),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_re     (mem_re),
      .mem_raddr  (mem_raddr),
      .meta       (meta)
   );

   lmcs_store #(.MSG_DEPTH(MSG_DEPTH)) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   lmcs_out u_out (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .meta             (meta),
      .rdata            (mem_rdata),
      .rsp_stall        (rsp_stall),
      .s1_free          (s1_free),
      .s1_valid         (s1_valid),
      .rsp_valid        (rsp_valid),
      .rsp_row_lines    (rsp_row_lines),
      .rsp_column_lines (rsp_column_lines),
      .rsp_running      (rsp_running),
      .rsp_done_res     (rsp_done_res)
   );

   `LMCS_ASSERT_NOW(a_done_not_running, rsp_valid, !(rsp_done_res && rsp_running), "done and run")
   `LMCS_ASSERT_NOW(a_column_onehot, rsp_active, $onehot(~rsp_column_lines), "bad column")
   `LMCS_ASSERT_NOW(a_write_when_idle, mem_we, !meta.running && !mem_re, "write while busy")
   `LMCS_ASSERT_NEXT(a_accept_fills_s1, accept, s1_valid, "accepted request lost")

endmodule
